FILE: rtl/sorted_depth_insert_list_core_defines.svh
// Assertion helpers shared by the RTL of the sorted insertion list.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SORTED_DEPTH_INSERT_LIST_CORE_DEFINES_SVH
`define SORTED_DEPTH_INSERT_LIST_CORE_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define SDIL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define SDIL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SDIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sdil_pkg.sv
`default_nettype none

package sdil_pkg;

  // Request codes
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_READOUT = 1'b1;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_ENTRY    = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

  // Width of the reported sorted position
  localparam int unsigned POS_W = 5;

  typedef logic [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

FILE: rtl/sdil_req_if.sv
`default_nettype none

// Request channel: insert or readout transactions.
interface sdil_req_if #(
  parameter int unsigned CW = 16,
  parameter int unsigned HW = 8
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic signed [CW-1:0] key_z;
  logic signed [CW-1:0] key_x;
  logic signed [CW-1:0] key_y;
  logic [HW-1:0]        handle;

  modport source (
    output valid, req_type, key_z, key_x, key_y, handle,
    input  ready
  );

  modport sink (
    input  valid, req_type, key_z, key_x, key_y, handle,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/sdil_rsp_if.sv
`default_nettype none

// Result channel: one transaction per status or readout entry.
interface sdil_rsp_if #(
  parameter int unsigned CW = 16,
  parameter int unsigned HW = 8
);
  logic                 valid;
  logic                 ready;
  sdil_pkg::status_t    status;
  logic [HW-1:0]        out_handle;
  logic signed [CW-1:0] out_z;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  sdil_pkg::pos_t       position;
  logic                 last;

  modport source (
    output valid, status, out_handle, out_z, out_x, out_y, position, last,
    input  ready
  );

  modport sink (
    input  valid, status, out_handle, out_z, out_x, out_y, position, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/sdil_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module sdil_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_depth_insert_list_core.sv
// Insert: into an empty table the entry is written at once; otherwise the
// stored entries at or after the insertion point are scanned from the top (one
// RAM read and one shifted write per cycle), then the new entry is placed.
// Full-table insert and empty readout go straight to the result. Readout walks
// each entry through the read, capture and output-load steps of the entry RAM.
// Reset clears the entry count and the output valid; the RAM is not cleared.
`default_nettype none
`include "sorted_depth_insert_list_core_defines.svh"

module sorted_depth_insert_list_core #(
  parameter int unsigned DEPTH        = 32,
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned HANDLE_WIDTH = 8
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  sdil_req_if.sink   req_i,
  sdil_rsp_if.source rsp_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned HW   = HANDLE_WIDTH;
  localparam int unsigned EW   = HW + 3 * CW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_TAIL     = 3'd2;
  localparam logic [2:0] S_RD_ISSUE = 3'd3;
  localparam logic [2:0] S_RD_DATA  = 3'd4;
  localparam logic [2:0] S_RESULT   = 3'd5;

  // Zero-extend or truncate a table index to the reported position width
  function automatic sdil_pkg::pos_t pos_of(input logic [AW-1:0] idx);
    logic [AW+sdil_pkg::POS_W-1:0] w;
    w = {{sdil_pkg::POS_W{1'b0}}, idx};
    return w[sdil_pkg::POS_W-1:0];
  endfunction

  logic [2:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]   scan_q, scan_d;
  logic [AW-1:0]   rd_idx_q, rd_idx_d;
  logic [EW-1:0]   nw_q, nw_d;

  sdil_pkg::status_t res_status_q, res_status_d;
  logic [EW-1:0]     res_ent_q, res_ent_d;
  sdil_pkg::pos_t    res_pos_q, res_pos_d;
  logic              res_last_q, res_last_d;

  logic              out_vld_q;
  sdil_pkg::status_t out_status_q;
  logic [EW-1:0]     out_ent_q;
  sdil_pkg::pos_t    out_pos_q;
  logic              out_last_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic          slot_free;
  logic          out_load;
  logic          ins_commit;
  logic [EW-1:0] req_ent;
  logic          new_gt;

  logic signed [CW-1:0] n_z, n_x, n_y, e_z, e_x, e_y;

  sdil_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pack the request into an entry: handle, z, x, y
  assign req_ent = {req_i.handle, req_i.key_z, req_i.key_x, req_i.key_y};

  // Compare the pending entry against the entry just read
  assign n_z = nw_q[3*CW-1 -: CW];
  assign n_x = nw_q[2*CW-1 -: CW];
  assign n_y = nw_q[CW-1:0];
  assign e_z = ram_rdata[3*CW-1 -: CW];
  assign e_x = ram_rdata[2*CW-1 -: CW];
  assign e_y = ram_rdata[CW-1:0];

  assign new_gt = (n_z > e_z) ||
                  ((n_z == e_z) && ((n_x > e_x) || ((n_x == e_x) && (n_y > e_y))));

  assign slot_free   = !out_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // Sequencer: scan and shift on insert, walk the table on readout
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    scan_d       = scan_q;
    rd_idx_d     = rd_idx_q;
    nw_d         = nw_q;
    res_status_d = res_status_q;
    res_ent_d    = res_ent_q;
    res_pos_d    = res_pos_q;
    res_last_d   = res_last_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = nw_q;
    ram_raddr    = rd_idx_q;
    out_load     = 1'b0;
    ins_commit   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.req_type == sdil_pkg::REQ_READOUT) begin
            if (cnt_q == '0) begin
              res_status_d = sdil_pkg::ST_EMPTY;
              res_ent_d    = '0;
              res_pos_d    = '0;
              res_last_d   = 1'b1;
              state_d      = S_RESULT;
            end else begin
              rd_idx_d = '0;
              state_d  = S_RD_ISSUE;
            end
          end else begin
            nw_d       = req_ent;
            res_ent_d  = req_ent;
            res_last_d = 1'b1;
            res_pos_d  = '0;
            if (cnt_q == CNTW'(DEPTH)) begin
              res_status_d = sdil_pkg::ST_FULL;
              state_d      = S_RESULT;
            end else if (cnt_q == '0) begin
              ram_we       = 1'b1;
              ram_waddr    = '0;
              ram_wdata    = req_ent;
              cnt_d        = CNTW'(1);
              ins_commit   = 1'b1;
              res_status_d = sdil_pkg::ST_INSERTED;
              state_d      = S_RESULT;
            end else begin
              ram_raddr = AW'(cnt_q - CNTW'(1));
              scan_d    = AW'(cnt_q - CNTW'(1));
              state_d   = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // Prefetch the next lower entry; writes only go above it
        ram_raddr = scan_q - AW'(1);
        ram_we    = 1'b1;
        ram_waddr = scan_q + AW'(1);
        if (new_gt) begin
          ram_wdata    = nw_q;
          cnt_d        = cnt_q + CNTW'(1);
          ins_commit   = 1'b1;
          res_status_d = sdil_pkg::ST_INSERTED;
          res_pos_d    = pos_of(scan_q + AW'(1));
          state_d      = S_RESULT;
        end else begin
          ram_wdata = ram_rdata;
          if (scan_q == '0) begin
            state_d = S_TAIL;
          end else begin
            scan_d = scan_q - AW'(1);
          end
        end
      end

      S_TAIL: begin
        // Place the new entry at the head
        ram_we       = 1'b1;
        ram_waddr    = '0;
        ram_wdata    = nw_q;
        cnt_d        = cnt_q + CNTW'(1);
        ins_commit   = 1'b1;
        res_status_d = sdil_pkg::ST_INSERTED;
        res_pos_d    = '0;
        state_d      = S_RESULT;
      end

      S_RD_ISSUE: begin
        ram_raddr = rd_idx_q;
        state_d   = S_RD_DATA;
      end

      S_RD_DATA: begin
        res_status_d = sdil_pkg::ST_ENTRY;
        res_ent_d    = ram_rdata;
        res_pos_d    = pos_of(rd_idx_q);
        res_last_d   = ((CNTW'(rd_idx_q) + CNTW'(1)) == cnt_q);
        state_d      = S_RESULT;
      end

      S_RESULT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (res_last_q) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + AW'(1);
            state_d  = S_RD_ISSUE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    rd_idx_q     <= rd_idx_d;
    nw_q         <= nw_d;
    res_status_q <= res_status_d;
    res_ent_q    <= res_ent_d;
    res_pos_q    <= res_pos_d;
    res_last_q   <= res_last_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_ent_q    <= res_ent_q;
      out_pos_q    <= res_pos_q;
      out_last_q   <= res_last_q;
    end
  end

  // Drive the result channel from the output register
  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.out_handle = out_ent_q[EW-1 -: HW];
  assign rsp_o.out_z      = out_ent_q[3*CW-1 -: CW];
  assign rsp_o.out_x      = out_ent_q[2*CW-1 -: CW];
  assign rsp_o.out_y      = out_ent_q[CW-1:0];
  assign rsp_o.position   = out_pos_q;
  assign rsp_o.last       = out_last_q;

  `SDIL_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNTW'(DEPTH), "entry count above depth")
  `SDIL_ASSERT_IMPL(a_scan_bound, state_q == S_SCAN, CNTW'(scan_q) < cnt_q, "scan past fill")
  `SDIL_ASSERT_IMPL(a_wr_bound, ram_we, CNTW'(ram_waddr) <= cnt_q, "write beyond fill")
  `SDIL_ASSERT_NEXT(a_ins_count, ins_commit, cnt_q == $past(cnt_q) + CNTW'(1), "count stuck")

endmodule

`default_nettype wire
